>>> sv/c8cpu_pkg.sv
// Package with the opcode decode tables, mode and operation codes and flag positions.
package c8cpu_pkg;

    localparam logic [15:0] VEC_LO     = 16'hFFFC;
    localparam logic [15:0] VEC_HI     = 16'hFFFD;
    localparam logic [7:0]  PULL_SET   = 8'h30;
    localparam logic [7:0]  STACK_PAGE = 8'h01;

    localparam int F_C = 0;
    localparam int F_Z = 1;
    localparam int F_I = 2;
    localparam int F_D = 3;
    localparam int F_V = 6;
    localparam int F_N = 7;

    typedef enum logic [4:0] {
        M_IMP, M_IMM, M_BR, M_ZP, M_ZPX, M_ABS, M_ABSX, M_ABSY, M_INDY, M_XIND,
        M_JMP, M_JSR, M_PHA, M_PHP, M_PLA, M_PLP, M_RTI, M_RTS
    } t_mode;

    typedef enum logic [4:0] {
        K_NONE, K_ORA, K_AND, K_BIT, K_ADC, K_SBC, K_LDA, K_LDX, K_LDY, K_STA,
        K_STX, K_STY, K_ASL, K_ROL, K_ASLA, K_CLC, K_SEC, K_CLI, K_SEI, K_CLV,
        K_CLD, K_SED, K_DEX, K_DEY, K_INX, K_INY, K_TXA, K_TYA, K_TXS, K_NOP
    } t_kind;

    typedef struct packed {
        logic  known;
        t_mode mode;
        t_kind kind;
    } t_dec;

    function automatic t_dec decode(input logic [7:0] op);
        t_dec d;
        d.known = 1'b1;
        d.mode  = M_IMP;
        d.kind  = K_NONE;
        unique case (op)
            8'h01: begin d.mode = M_XIND; d.kind = K_ORA; end
            8'h05: begin d.mode = M_ZP;   d.kind = K_ORA; end
            8'h06: begin d.mode = M_ZP;   d.kind = K_ASL; end
            8'h08: begin d.mode = M_PHP;  end
            8'h09: begin d.mode = M_IMM;  d.kind = K_ORA; end
            8'h0a: begin d.kind = K_ASLA; end
            8'h0d: begin d.mode = M_ABS;  d.kind = K_ORA; end
            8'h0e: begin d.mode = M_ABS;  d.kind = K_ASL; end
            8'h10: begin d.mode = M_BR;   end
            8'h11: begin d.mode = M_INDY; d.kind = K_ORA; end
            8'h15: begin d.mode = M_ZPX;  d.kind = K_ORA; end
            8'h16: begin d.mode = M_ZPX;  d.kind = K_ASL; end
            8'h18: begin d.kind = K_CLC; end
            8'h19: begin d.mode = M_ABSY; d.kind = K_ORA; end
            8'h1d: begin d.mode = M_ABSX; d.kind = K_ORA; end
            8'h1e: begin d.mode = M_ABSX; d.kind = K_ASL; end
            8'h20: begin d.mode = M_JSR;  end
            8'h21: begin d.mode = M_XIND; d.kind = K_AND; end
            8'h24: begin d.mode = M_ZP;   d.kind = K_BIT; end
            8'h25: begin d.mode = M_ZP;   d.kind = K_AND; end
            8'h26: begin d.mode = M_ZP;   d.kind = K_ROL; end
            8'h28: begin d.mode = M_PLP;  end
            8'h29: begin d.mode = M_IMM;  d.kind = K_AND; end
            8'h2c: begin d.mode = M_ABS;  d.kind = K_BIT; end
            8'h2d: begin d.mode = M_ABS;  d.kind = K_AND; end
            8'h2e: begin d.mode = M_ABS;  d.kind = K_ROL; end
            8'h30: begin d.mode = M_BR;   end
            8'h31: begin d.mode = M_INDY; d.kind = K_AND; end
            8'h34: begin d.mode = M_ZPX;  d.kind = K_BIT; end
            8'h35: begin d.mode = M_ZPX;  d.kind = K_AND; end
            8'h38: begin d.kind = K_SEC; end
            8'h39: begin d.mode = M_ABSY; d.kind = K_AND; end
            8'h3c: begin d.mode = M_ABSX; d.kind = K_BIT; end
            8'h3d: begin d.mode = M_ABSX; d.kind = K_AND; end
            8'h40: begin d.mode = M_RTI;  end
            8'h48: begin d.mode = M_PHA;  end
            8'h4c: begin d.mode = M_JMP;  end
            8'h50: begin d.mode = M_BR;   end
            8'h58: begin d.kind = K_CLI; end
            8'h60: begin d.mode = M_RTS;  end
            8'h61: begin d.mode = M_XIND; d.kind = K_ADC; end
            8'h65: begin d.mode = M_ZP;   d.kind = K_ADC; end
            8'h68: begin d.mode = M_PLA;  end
            8'h69: begin d.mode = M_IMM;  d.kind = K_ADC; end
            8'h6d: begin d.mode = M_ABS;  d.kind = K_ADC; end
            8'h70: begin d.mode = M_BR;   end
            8'h71: begin d.mode = M_INDY; d.kind = K_ADC; end
            8'h75: begin d.mode = M_ZPX;  d.kind = K_ADC; end
            8'h78: begin d.kind = K_SEI; end
            8'h79: begin d.mode = M_ABSY; d.kind = K_ADC; end
            8'h7d: begin d.mode = M_ABSX; d.kind = K_ADC; end
            8'h85: begin d.mode = M_ZP;   d.kind = K_STA; end
            8'h88: begin d.kind = K_DEY; end
            8'h89: begin d.mode = M_IMM;  d.kind = K_BIT; end
            8'h8a: begin d.kind = K_TXA; end
            8'h8c: begin d.mode = M_ABS;  d.kind = K_STY; end
            8'h8d: begin d.mode = M_ABS;  d.kind = K_STA; end
            8'h8e: begin d.mode = M_ABS;  d.kind = K_STX; end
            8'h90: begin d.mode = M_BR;   end
            8'h98: begin d.kind = K_TYA; end
            8'h9a: begin d.kind = K_TXS; end
            8'ha0: begin d.mode = M_IMM;  d.kind = K_LDY; end
            8'ha2: begin d.mode = M_IMM;  d.kind = K_LDX; end
            8'ha5: begin d.mode = M_ZP;   d.kind = K_LDA; end
            8'ha9: begin d.mode = M_IMM;  d.kind = K_LDA; end
            8'had: begin d.mode = M_ABS;  d.kind = K_LDA; end
            8'hb0: begin d.mode = M_BR;   end
            8'hb1: begin d.mode = M_INDY; d.kind = K_LDA; end
            8'hb5: begin d.mode = M_ZPX;  d.kind = K_LDA; end
            8'hb8: begin d.kind = K_CLV; end
            8'hb9: begin d.mode = M_ABSY; d.kind = K_LDA; end
            8'hbd: begin d.mode = M_ABSX; d.kind = K_LDA; end
            8'hc8: begin d.kind = K_INY; end
            8'hca: begin d.kind = K_DEX; end
            8'hd0: begin d.mode = M_BR;   end
            8'hd8: begin d.kind = K_CLD; end
            8'he1: begin d.mode = M_XIND; d.kind = K_SBC; end
            8'he5: begin d.mode = M_ZP;   d.kind = K_SBC; end
            8'he8: begin d.kind = K_INX; end
            8'he9: begin d.mode = M_IMM;  d.kind = K_SBC; end
            8'hea: begin d.kind = K_NOP; end
            8'hed: begin d.mode = M_ABS;  d.kind = K_SBC; end
            8'hf0: begin d.mode = M_BR;   end
            8'hf1: begin d.mode = M_INDY; d.kind = K_SBC; end
            8'hf5: begin d.mode = M_ZPX;  d.kind = K_SBC; end
            8'hf8: begin d.kind = K_SED; end
            8'hf9: begin d.mode = M_ABSY; d.kind = K_SBC; end
            8'hfd: begin d.mode = M_ABSX; d.kind = K_SBC; end
            default: begin d.known = 1'b0; end
        endcase
        return d;
    endfunction

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
    } t_regs;

endpackage

>>> sv/c8cpu_alu.sv
// Arithmetic and logic unit for the read operations and the implied-mode operations.
module c8cpu_alu (
    input  c8cpu_pkg::t_kind i_kind,
    input  logic             i_is_read,
    input  logic [7:0]       i_data,
    input  c8cpu_pkg::t_regs i_regs,
    output c8cpu_pkg::t_regs o_regs
);

    logic [8:0] sum;
    logic [7:0] nzv;
    logic       set_nz;

    always_comb begin
        o_regs = i_regs;
        sum    = 9'd0;
        nzv    = 8'd0;
        set_nz = 1'b0;
        if (i_is_read) begin
            unique case (i_kind)
                c8cpu_pkg::K_ORA: begin
                    o_regs.a = i_regs.a | i_data; nzv = o_regs.a; set_nz = 1'b1;
                end
                c8cpu_pkg::K_AND: begin
                    o_regs.a = i_regs.a & i_data; nzv = o_regs.a; set_nz = 1'b1;
                end
                c8cpu_pkg::K_BIT: begin
                    o_regs.p[c8cpu_pkg::F_N] = i_data[7];
                    o_regs.p[c8cpu_pkg::F_V] = i_data[6];
                    o_regs.p[c8cpu_pkg::F_Z] = ((i_regs.a & i_data) == 8'd0);
                end
                c8cpu_pkg::K_ADC: begin
                    sum = {1'b0, i_regs.a} + {1'b0, i_data} + {8'd0, i_regs.p[c8cpu_pkg::F_C]};
                    o_regs.p[c8cpu_pkg::F_V] = ~(i_regs.a[7] ^ i_data[7])
                        & (i_regs.a[7] ^ sum[7]);
                    o_regs.p[c8cpu_pkg::F_C] = sum[8];
                    o_regs.a = sum[7:0]; nzv = sum[7:0]; set_nz = 1'b1;
                end
                c8cpu_pkg::K_SBC: begin
                    sum = {1'b0, i_regs.a} - {1'b0, i_data}
                        - {8'd0, ~i_regs.p[c8cpu_pkg::F_C]};
                    o_regs.p[c8cpu_pkg::F_V] = (i_regs.a[7] ^ i_data[7])
                        & (i_regs.a[7] ^ sum[7]);
                    o_regs.p[c8cpu_pkg::F_C] = ~sum[8];
                    o_regs.a = sum[7:0]; nzv = sum[7:0]; set_nz = 1'b1;
                end
                c8cpu_pkg::K_LDA: begin o_regs.a = i_data; nzv = i_data; set_nz = 1'b1; end
                c8cpu_pkg::K_LDX: begin o_regs.x = i_data; nzv = i_data; set_nz = 1'b1; end
                c8cpu_pkg::K_LDY: begin o_regs.y = i_data; nzv = i_data; set_nz = 1'b1; end
                default: begin end
            endcase
        end else begin
            unique case (i_kind)
                c8cpu_pkg::K_ASLA: begin
                    o_regs.p[c8cpu_pkg::F_C] = i_regs.a[7];
                    o_regs.a = {i_regs.a[6:0], 1'b0}; nzv = o_regs.a; set_nz = 1'b1;
                end
                c8cpu_pkg::K_CLC: o_regs.p[c8cpu_pkg::F_C] = 1'b0;
                c8cpu_pkg::K_SEC: o_regs.p[c8cpu_pkg::F_C] = 1'b1;
                c8cpu_pkg::K_CLI: o_regs.p[c8cpu_pkg::F_I] = 1'b0;
                c8cpu_pkg::K_SEI: o_regs.p[c8cpu_pkg::F_I] = 1'b1;
                c8cpu_pkg::K_CLV: o_regs.p[c8cpu_pkg::F_V] = 1'b0;
                c8cpu_pkg::K_CLD: o_regs.p[c8cpu_pkg::F_D] = 1'b0;
                c8cpu_pkg::K_SED: o_regs.p[c8cpu_pkg::F_D] = 1'b1;
                c8cpu_pkg::K_DEX: begin
                    o_regs.x = i_regs.x - 8'd1; nzv = o_regs.x; set_nz = 1'b1;
                end
                c8cpu_pkg::K_DEY: begin
                    o_regs.y = i_regs.y - 8'd1; nzv = o_regs.y; set_nz = 1'b1;
                end
                c8cpu_pkg::K_INX: begin
                    o_regs.x = i_regs.x + 8'd1; nzv = o_regs.x; set_nz = 1'b1;
                end
                c8cpu_pkg::K_INY: begin
                    o_regs.y = i_regs.y + 8'd1; nzv = o_regs.y; set_nz = 1'b1;
                end
                c8cpu_pkg::K_TXA: begin o_regs.a = i_regs.x; nzv = i_regs.x; set_nz = 1'b1; end
                c8cpu_pkg::K_TYA: begin o_regs.a = i_regs.y; nzv = i_regs.y; set_nz = 1'b1; end
                c8cpu_pkg::K_TXS: o_regs.s = i_regs.x;
                default: begin end
            endcase
        end
        if (set_nz) begin
            o_regs.p[c8cpu_pkg::F_N] = nzv[7];
            o_regs.p[c8cpu_pkg::F_Z] = (nzv == 8'd0);
        end
    end

endmodule

>>> sv/cycle_level_8bit_cpu_core.sv
// Top level of the bus-cycle-level 8-bit processor core.
// Each input beat closes one bus cycle (read data and reset line) and yields exactly one
// output beat that announces the next bus access. A beat is taken every clock cycle unless the
// consumer holds back a pending access: the next access is computed combinationally from the
// registered state, and the result register frees itself when the consumer takes the previous
// access in the same cycle. After reset the core waits at the start of the reset sequence,
// so the first input beat completes the read of the reset vector low byte.
module cycle_level_8bit_cpu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_read_data,
    input  logic        i_reset_line,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_bus_address,
    output logic        o_bus_write,
    output logic [7:0]  o_write_data,
    output logic        o_opcode_fetch,
    output logic        o_halted
);

    c8cpu_pkg::t_regs r_regs, n_regs, alu_regs;
    logic [15:0] r_pc, n_pc, r_ea, n_ea;
    logic [7:0]  r_op, n_op, r_lat, n_lat;
    logic [2:0]  r_step, n_step;
    logic        r_halt, n_halt, r_vec, n_vec;
    logic [15:0] n_addr;
    logic        n_wr, n_sync;
    logic [7:0]  n_wdata;
    logic        r_valid;
    logic        accept;

    c8cpu_pkg::t_dec dec, cur;
    c8cpu_pkg::t_kind alu_kind;
    logic        alu_read;
    logic [7:0]  alu_data;
    logic [8:0]  isum, shv;
    logic [15:0] pc1, brt;
    logic [7:0]  rdx;
    logic        is_store, is_rmw, taken;
    logic [2:0]  bsel;

    assign o_ready = ~r_valid | i_ready;
    assign accept  = i_valid & o_ready;
    assign o_valid = r_valid;

    c8cpu_alu u_alu (
        .i_kind    (alu_kind),
        .i_is_read (alu_read),
        .i_data    (alu_data),
        .i_regs    (r_regs),
        .o_regs    (alu_regs)
    );

    always_comb begin
        dec      = c8cpu_pkg::decode(i_read_data);
        cur      = c8cpu_pkg::decode(r_op);
        is_store = (cur.kind == c8cpu_pkg::K_STA) || (cur.kind == c8cpu_pkg::K_STX)
                 || (cur.kind == c8cpu_pkg::K_STY);
        is_rmw   = (cur.kind == c8cpu_pkg::K_ASL) || (cur.kind == c8cpu_pkg::K_ROL);
        pc1      = r_pc + 16'd1;
        bsel     = 3'd0;
        unique case (r_op[7:6])
            2'd0: bsel = 3'd7;
            2'd1: bsel = 3'd6;
            2'd2: bsel = 3'd0;
            default: bsel = 3'd1;
        endcase
        taken = (r_regs.p[bsel] == r_op[5]);
        brt   = r_pc + {{8{r_lat[7]}}, r_lat};
        rdx   = (cur.mode == c8cpu_pkg::M_INDY || cur.mode == c8cpu_pkg::M_ABSY)
              ? r_regs.y : r_regs.x;
        isum  = {1'b0, r_ea[7:0]} + {1'b0, rdx};
        shv   = {r_lat, (cur.kind == c8cpu_pkg::K_ROL) ? r_regs.p[c8cpu_pkg::F_C] : 1'b0};

        n_regs  = r_regs;
        n_pc    = r_pc;
        n_ea    = r_ea;
        n_op    = r_op;
        n_lat   = r_lat;
        n_step  = r_step;
        n_halt  = r_halt;
        n_vec   = r_vec;
        n_addr  = r_pc;
        n_wr    = 1'b0;
        n_wdata = 8'd0;
        n_sync  = 1'b0;
        alu_kind = cur.kind;
        alu_read = 1'b0;
        alu_data = i_read_data;

        if (i_reset_line) begin
            n_halt = 1'b0; n_vec = 1'b1; n_step = 3'd0; n_addr = c8cpu_pkg::VEC_LO;
        end else if (r_halt) begin
            n_addr = r_pc;
        end else if (r_vec) begin
            if (r_step == 3'd0) begin
                n_pc = {r_pc[15:8], i_read_data}; n_step = 3'd1; n_addr = c8cpu_pkg::VEC_HI;
            end else begin
                n_pc = {i_read_data, r_pc[7:0]}; n_vec = 1'b0;
                n_addr = {i_read_data, r_pc[7:0]}; n_sync = 1'b1; n_step = 3'd0;
            end
        end else if (r_step == 3'd0) begin
            n_op = i_read_data; n_pc = pc1; n_addr = pc1;
            if (!dec.known) n_halt = 1'b1;
            else n_step = 3'd1;
        end else if ((cur.mode == c8cpu_pkg::M_ZP || cur.mode == c8cpu_pkg::M_ZPX
                   || cur.mode == c8cpu_pkg::M_ABS || cur.mode == c8cpu_pkg::M_ABSX
                   || cur.mode == c8cpu_pkg::M_ABSY || cur.mode == c8cpu_pkg::M_INDY
                   || cur.mode == c8cpu_pkg::M_XIND) && r_step >= 3'd5) begin
            if (r_step == 3'd5) begin
                if (is_store) begin
                    n_sync = 1'b1; n_step = 3'd0;
                end else if (is_rmw) begin
                    n_lat = i_read_data; n_step = 3'd6; n_addr = r_ea;
                    n_wr = 1'b1; n_wdata = i_read_data;
                end else begin
                    alu_read = 1'b1; n_regs = alu_regs; n_sync = 1'b1; n_step = 3'd0;
                end
            end else if (r_step == 3'd6) begin
                n_regs.p[c8cpu_pkg::F_C] = shv[8];
                n_regs.p[c8cpu_pkg::F_N] = shv[7];
                n_regs.p[c8cpu_pkg::F_Z] = (shv[7:0] == 8'd0);
                n_lat = shv[7:0]; n_step = 3'd7; n_addr = r_ea;
                n_wr = 1'b1; n_wdata = shv[7:0];
            end else begin
                n_sync = 1'b1; n_step = 3'd0;
            end
        end else begin
            // Default is an opcode fetch at the current program counter.
            n_sync = 1'b1; n_step = 3'd0;
            unique case (cur.mode)
                c8cpu_pkg::M_IMP: if (r_step == 3'd1) n_regs = alu_regs;
                c8cpu_pkg::M_IMM: if (r_step == 3'd1) begin
                    alu_read = 1'b1; n_regs = alu_regs; n_pc = pc1; n_addr = pc1;
                end
                c8cpu_pkg::M_BR: begin
                    if (r_step == 3'd1) begin
                        n_pc = pc1; n_addr = pc1; n_lat = i_read_data;
                        if (taken) begin n_sync = 1'b0; n_step = 3'd2; end
                    end else if (r_step == 3'd2) begin
                        if (brt[15:8] != r_pc[15:8]) begin
                            n_pc = {r_pc[15:8], brt[7:0]}; n_ea = brt;
                            n_addr = {r_pc[15:8], brt[7:0]}; n_sync = 1'b0; n_step = 3'd3;
                        end else begin
                            n_pc = brt; n_addr = brt;
                        end
                    end else if (r_step == 3'd3) begin
                        n_pc = r_ea; n_addr = r_ea;
                    end
                end
                c8cpu_pkg::M_ZP: if (r_step == 3'd1) begin
                    n_pc = pc1; n_ea = {8'd0, i_read_data}; n_sync = 1'b0; n_step = 3'd5;
                    n_addr = {8'd0, i_read_data};
                end
                c8cpu_pkg::M_ZPX: begin
                    if (r_step == 3'd1) begin
                        n_pc = pc1; n_ea = {8'd0, i_read_data}; n_sync = 1'b0; n_step = 3'd2;
                        n_addr = {8'd0, i_read_data};
                    end else if (r_step == 3'd2) begin
                        n_ea = {8'd0, isum[7:0]}; n_sync = 1'b0; n_step = 3'd5;
                        n_addr = {8'd0, isum[7:0]};
                    end
                end
                c8cpu_pkg::M_ABS, c8cpu_pkg::M_JMP, c8cpu_pkg::M_ABSX,
                c8cpu_pkg::M_ABSY: begin
                    if (r_step == 3'd1) begin
                        n_pc = pc1; n_ea = {8'd0, i_read_data}; n_sync = 1'b0;
                        n_step = 3'd2; n_addr = pc1;
                    end else if (r_step == 3'd2) begin
                        if (cur.mode == c8cpu_pkg::M_JMP) begin
                            n_pc = {i_read_data, r_ea[7:0]}; n_addr = {i_read_data, r_ea[7:0]};
                        end else if (cur.mode == c8cpu_pkg::M_ABS) begin
                            n_pc = pc1; n_ea = {i_read_data, r_ea[7:0]}; n_sync = 1'b0;
                            n_step = 3'd5; n_addr = {i_read_data, r_ea[7:0]};
                        end else begin
                            n_pc = pc1; n_ea = {i_read_data, 8'd0} + {7'd0, isum};
                            n_sync = 1'b0;
                            if (isum[8] || (cur.mode == c8cpu_pkg::M_ABSX && is_rmw)) begin
                                n_step = 3'd3; n_addr = {i_read_data, isum[7:0]};
                            end else begin
                                n_step = 3'd5; n_addr = {i_read_data, 8'd0} + {7'd0, isum};
                            end
                        end
                    end else if (r_step == 3'd3) begin
                        n_sync = 1'b0; n_step = 3'd5; n_addr = r_ea;
                    end
                end
                c8cpu_pkg::M_INDY, c8cpu_pkg::M_XIND: begin
                    n_sync = 1'b0;
                    if (r_step == 3'd1) begin
                        n_pc = pc1; n_lat = i_read_data; n_step = 3'd2;
                        n_addr = {8'd0, i_read_data};
                    end else if (cur.mode == c8cpu_pkg::M_INDY) begin
                        if (r_step == 3'd2) begin
                            n_ea = {8'd0, i_read_data}; n_step = 3'd3;
                            n_addr = {8'd0, r_lat + 8'd1};
                        end else if (r_step == 3'd3) begin
                            n_ea = {i_read_data, 8'd0} + {7'd0, isum};
                            if (isum[8]) begin
                                n_step = 3'd4; n_addr = {i_read_data, isum[7:0]};
                            end else begin
                                n_step = 3'd5; n_addr = {i_read_data, 8'd0} + {7'd0, isum};
                            end
                        end else begin
                            n_step = 3'd5; n_addr = r_ea;
                        end
                    end else begin
                        if (r_step == 3'd2) begin
                            n_lat = r_lat + r_regs.x; n_step = 3'd3;
                            n_addr = {8'd0, r_lat + r_regs.x};
                        end else if (r_step == 3'd3) begin
                            n_ea = {8'd0, i_read_data}; n_step = 3'd4;
                            n_addr = {8'd0, r_lat + 8'd1};
                        end else begin
                            n_ea = {i_read_data, r_ea[7:0]}; n_step = 3'd5;
                            n_addr = {i_read_data, r_ea[7:0]};
                        end
                    end
                    if (n_step == 3'd5 && is_store) begin
                        n_wr = 1'b1;
                        n_wdata = r_regs.a;
                    end
                end
                c8cpu_pkg::M_PHA, c8cpu_pkg::M_PHP: begin
                    if (r_step == 3'd1) begin
                        n_sync = 1'b0; n_step = 3'd2; n_addr = {c8cpu_pkg::STACK_PAGE, r_regs.s};
                        n_wr = 1'b1;
                        n_wdata = (cur.mode == c8cpu_pkg::M_PHA) ? r_regs.a : r_regs.p;
                    end else begin
                        n_regs.s = r_regs.s - 8'd1;
                    end
                end
                c8cpu_pkg::M_PLA, c8cpu_pkg::M_PLP, c8cpu_pkg::M_RTI,
                c8cpu_pkg::M_RTS: begin
                    if (r_step == 3'd1) begin
                        n_sync = 1'b0; n_step = 3'd2; n_addr = {c8cpu_pkg::STACK_PAGE, r_regs.s};
                    end else if (r_step == 3'd2) begin
                        n_regs.s = r_regs.s + 8'd1; n_sync = 1'b0; n_step = 3'd3;
                        n_addr = {c8cpu_pkg::STACK_PAGE, r_regs.s + 8'd1};
                    end else if (cur.mode == c8cpu_pkg::M_PLA) begin
                        n_regs.a = i_read_data;
                        n_regs.p[c8cpu_pkg::F_N] = i_read_data[7];
                        n_regs.p[c8cpu_pkg::F_Z] = (i_read_data == 8'd0);
                    end else if (cur.mode == c8cpu_pkg::M_PLP) begin
                        n_regs.p = i_read_data | c8cpu_pkg::PULL_SET;
                    end else if (cur.mode == c8cpu_pkg::M_RTI && r_step == 3'd3) begin
                        n_regs.p = i_read_data | c8cpu_pkg::PULL_SET;
                        n_regs.s = r_regs.s + 8'd1; n_sync = 1'b0; n_step = 3'd4;
                        n_addr = {c8cpu_pkg::STACK_PAGE, r_regs.s + 8'd1};
                    end else if ((cur.mode == c8cpu_pkg::M_RTI && r_step == 3'd4)
                              || (cur.mode == c8cpu_pkg::M_RTS && r_step == 3'd3)) begin
                        n_pc = {r_pc[15:8], i_read_data};
                        n_regs.s = r_regs.s + 8'd1; n_sync = 1'b0; n_step = r_step + 3'd1;
                        n_addr = {c8cpu_pkg::STACK_PAGE, r_regs.s + 8'd1};
                    end else if (cur.mode == c8cpu_pkg::M_RTI) begin
                        n_pc = {i_read_data, r_pc[7:0]}; n_addr = {i_read_data, r_pc[7:0]};
                    end else if (r_step == 3'd4) begin
                        n_pc = {i_read_data, r_pc[7:0]}; n_sync = 1'b0; n_step = 3'd5;
                        n_addr = {i_read_data, r_pc[7:0]};
                    end else begin
                        n_pc = pc1; n_addr = pc1;
                    end
                end
                c8cpu_pkg::M_JSR: begin
                    n_sync = 1'b0;
                    if (r_step == 3'd1) begin
                        n_pc = pc1; n_lat = i_read_data; n_step = 3'd2;
                        n_addr = {c8cpu_pkg::STACK_PAGE, r_regs.s};
                    end else if (r_step == 3'd2) begin
                        n_step = 3'd3; n_addr = {c8cpu_pkg::STACK_PAGE, r_regs.s};
                        n_wr = 1'b1; n_wdata = r_pc[15:8];
                    end else if (r_step == 3'd3) begin
                        n_regs.s = r_regs.s - 8'd1; n_step = 3'd4;
                        n_addr = {c8cpu_pkg::STACK_PAGE, r_regs.s - 8'd1};
                        n_wr = 1'b1; n_wdata = r_pc[7:0];
                    end else if (r_step == 3'd4) begin
                        n_regs.s = r_regs.s - 8'd1; n_step = 3'd5;
                    end else begin
                        n_pc = {i_read_data, r_lat}; n_addr = {i_read_data, r_lat};
                        n_sync = 1'b1; n_step = 3'd0;
                    end
                end
                default: begin end
            endcase
            if (n_wr && n_step == 3'd5 && cur.mode != c8cpu_pkg::M_JSR) begin
                unique case (cur.kind)
                    c8cpu_pkg::K_STX: n_wdata = r_regs.x;
                    c8cpu_pkg::K_STY: n_wdata = r_regs.y;
                    default: n_wdata = r_regs.a;
                endcase
            end
            if (!n_wr && n_step == 3'd5 && is_store && cur.mode != c8cpu_pkg::M_JSR
                && cur.mode != c8cpu_pkg::M_RTS) begin
                n_wr = 1'b1;
                unique case (cur.kind)
                    c8cpu_pkg::K_STX: n_wdata = r_regs.x;
                    c8cpu_pkg::K_STY: n_wdata = r_regs.y;
                    default: n_wdata = r_regs.a;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs  <= '0;
            r_pc    <= 16'd0;
            r_ea    <= 16'd0;
            r_op    <= 8'd0;
            r_lat   <= 8'd0;
            r_step  <= 3'd0;
            r_halt  <= 1'b0;
            r_vec   <= 1'b1;
            r_valid <= 1'b0;
            o_bus_address  <= c8cpu_pkg::VEC_LO;
            o_bus_write    <= 1'b0;
            o_write_data   <= 8'd0;
            o_opcode_fetch <= 1'b0;
            o_halted       <= 1'b0;
        end else begin
            if (accept) begin
                r_regs  <= n_regs;
                r_pc    <= n_pc;
                r_ea    <= n_ea;
                r_op    <= n_op;
                r_lat   <= n_lat;
                r_step  <= n_step;
                r_halt  <= n_halt;
                r_vec   <= n_vec;
                r_valid <= 1'b1;
                o_bus_address  <= n_addr;
                o_bus_write    <= n_wr;
                o_write_data   <= n_wdata;
                o_opcode_fetch <= n_sync;
                o_halted       <= n_halt;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_write_in_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_reset_line |=> !o_bus_write && o_bus_address == c8cpu_pkg::VEC_LO)
        else $error("write announced while reset line was high");
    a_halt_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_halted |-> !o_bus_write && !o_opcode_fetch)
        else $error("halted core announced a write or fetch");
    a_wdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bus_write |-> o_write_data == 8'd0)
        else $error("write data nonzero on a read");
    a_fetch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_opcode_fetch |-> r_step == 3'd0 && !r_vec)
        else $error("fetch announced outside instruction start");
`endif

endmodule
